// ===== rtl/core/track_matte_pixel_masker_defines.svh =====
// ----------------------------------------------------------------------------
// Track matte pixel masker: assertion macros
// Shared concurrent assertion wrappers, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef TRACK_MATTE_PIXEL_MASKER_DEFINES_SVH
`define TRACK_MATTE_PIXEL_MASKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define TMPM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmpm assertion failed");
// Next-cycle implication
`define TMPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmpm assertion failed");
`else
`define TMPM_ASSERT_NOW(lbl, ante, cons)
`define TMPM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/tmpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Track matte pixel masker package
// Matte mode codes, default channel width and Rec.709 luma coefficients.
// ----------------------------------------------------------------------------
package tmpm_pkg;

  localparam int TMPM_CHANNEL_BITS = 16;
  localparam int MODE_BITS         = 3;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NONE      = 3'd0,
    MODE_ALPHA     = 3'd1,
    MODE_ALPHA_INV = 3'd2,
    MODE_LUMA      = 3'd3,
    MODE_LUMA_INV  = 3'd4
  } mode_t;

  // Rec.709 luma weights over 2^16; they sum to exactly 65536
  localparam int          LUMA_SHIFT = 16;
  localparam logic [15:0] LUMA_KR    = 16'd13933;
  localparam logic [15:0] LUMA_KG    = 16'd46872;
  localparam logic [15:0] LUMA_KB    = 16'd4731;
  localparam logic [15:0] LUMA_HALF  = 16'd32768;

endpackage

// ===== rtl/core/track_matte_pixel_masker.sv =====
// ----------------------------------------------------------------------------
// Track matte pixel masker
// Scales a layer pixel by a weight taken from the matching matte pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one layer pixel and the matching
//   matte pixel per item. Result channel (out_valid/out_ready) carries the
//   masked layer pixel. Channels are unsigned, all ones means 1.0.
//   cfg_wr_en/cfg_wr_data write matte_mode (0 none, 1 alpha, 2 alpha
//   inverted, 3 luma, 4 luma inverted; 5..7 act as none). Write it only while
//   the pipeline is empty; each item takes the mode current when it enters.
//   Throughput: one item per cycle while the receiver does not stall, set
//   by a six stage pipeline with one register level per stage: luma
//   products, luma sum, luma times alpha, weight, channel products,
//   rounding.
//   Each stage has its own valid bit and loads when it is empty or when the
//   stage after it loads, so bubbles are squeezed out while the receiver
//   stalls and in_ready stays high until every stage holds an item.
//   Reset (rst_n low, synchronous) empties the pipeline and sets the mode to
//   none; data registers are not reset.
// ----------------------------------------------------------------------------
`include "track_matte_pixel_masker_defines.svh"

module track_matte_pixel_masker #(
  parameter int CHANNEL_BITS = tmpm_pkg::TMPM_CHANNEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [tmpm_pkg::MODE_BITS-1:0]      cfg_wr_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [CHANNEL_BITS-1:0]             in_layer_red,
  input  logic [CHANNEL_BITS-1:0]             in_layer_green,
  input  logic [CHANNEL_BITS-1:0]             in_layer_blue,
  input  logic [CHANNEL_BITS-1:0]             in_layer_alpha,
  input  logic [CHANNEL_BITS-1:0]             in_matte_red,
  input  logic [CHANNEL_BITS-1:0]             in_matte_green,
  input  logic [CHANNEL_BITS-1:0]             in_matte_blue,
  input  logic [CHANNEL_BITS-1:0]             in_matte_alpha,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [CHANNEL_BITS-1:0]             out_red,
  output logic [CHANNEL_BITS-1:0]             out_green,
  output logic [CHANNEL_BITS-1:0]             out_blue,
  output logic [CHANNEL_BITS-1:0]             out_alpha
);
  import tmpm_pkg::*;

  localparam int N      = CHANNEL_BITS;
  localparam int PW     = N + 16;       // luma product width
  localparam int SW     = N + 18;       // luma sum width
  localparam int NSTAGE = 6;
  localparam int NCH    = 4;
  localparam logic [2*N:0] RND_HALF = (2*N+1)'(1) << (N - 1);

  // Round p / (2^N - 1) to nearest for p up to (2^N - 1)^2; halves cannot
  // occur because the divisor is odd.
  function automatic logic [N-1:0] div_round(input logic [2*N-1:0] p);
    logic [2*N:0] t;
    logic [2*N:0] s;
    t = (2*N+1)'(p) + RND_HALF;
    s = t + (t >> N);
    return s[2*N-1:N];
  endfunction

  // --------------------------------------------------------------------------
  // Mode register
  // --------------------------------------------------------------------------
  mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
    end else if (cfg_wr_en) begin
      mode_r <= mode_t'(cfg_wr_data);
    end
  end

  // --------------------------------------------------------------------------
  // Stage valid bits and load enables
  // ld[k]: stage k takes a new item (or a bubble) this cycle.
  // --------------------------------------------------------------------------
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] ld;

  always_comb begin
    ld[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[NSTAGE-1];

  // --------------------------------------------------------------------------
  // Stage 0: capture pixel, take the three luma products
  // --------------------------------------------------------------------------
  logic [PW-1:0] pr0_r, pg0_r, pb0_r;
  logic [N-1:0]  ma0_r;
  logic [N-1:0]  layer0_r [NCH];
  mode_t         mode0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      pr0_r       <= PW'(LUMA_KR) * PW'(in_matte_red);
      pg0_r       <= PW'(LUMA_KG) * PW'(in_matte_green);
      pb0_r       <= PW'(LUMA_KB) * PW'(in_matte_blue);
      ma0_r       <= in_matte_alpha;
      layer0_r[0] <= in_layer_red;
      layer0_r[1] <= in_layer_green;
      layer0_r[2] <= in_layer_blue;
      layer0_r[3] <= in_layer_alpha;
      mode0_r     <= mode_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sum the luma products, round, drop the coefficient scale
  // --------------------------------------------------------------------------
  logic [SW-1:0] lsum;
  logic [N-1:0]  luma1_r;
  logic [N-1:0]  ma1_r;
  logic [N-1:0]  layer1_r [NCH];
  mode_t         mode1_r;

  assign lsum = SW'(pr0_r) + SW'(pg0_r) + SW'(pb0_r) + SW'(LUMA_HALF);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      luma1_r  <= lsum[N+LUMA_SHIFT-1:LUMA_SHIFT];
      ma1_r    <= ma0_r;
      layer1_r <= layer0_r;
      mode1_r  <= mode0_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: luma times matte alpha
  // --------------------------------------------------------------------------
  logic [2*N-1:0] lp2_r;
  logic [N-1:0]   ma2_r;
  logic [N-1:0]   layer2_r [NCH];
  mode_t          mode2_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      lp2_r    <= (2*N)'(luma1_r) * (2*N)'(ma1_r);
      ma2_r    <= ma1_r;
      layer2_r <= layer1_r;
      mode2_r  <= mode1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: pick the weight by mode
  // --------------------------------------------------------------------------
  logic [N-1:0] lw;
  logic [N-1:0] w_nxt;
  logic         pass_nxt;
  logic [N-1:0] w3_r;
  logic         pass3_r;
  logic [N-1:0] layer3_r [NCH];

  assign lw = div_round(lp2_r);

  always_comb begin
    w_nxt    = '1;
    pass_nxt = 1'b0;
    case (mode2_r)
      MODE_ALPHA:     w_nxt = ma2_r;
      MODE_ALPHA_INV: w_nxt = ~ma2_r;
      MODE_LUMA:      w_nxt = lw;
      MODE_LUMA_INV:  w_nxt = ~lw;
      default:        pass_nxt = 1'b1;  // none and unused codes
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      w3_r     <= w_nxt;
      pass3_r  <= pass_nxt;
      layer3_r <= layer2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: each channel times weight
  // --------------------------------------------------------------------------
  logic [2*N-1:0] prod4_r [NCH];
  logic           pass4_r;
  logic [N-1:0]   layer4_r [NCH];

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int c = 0; c < NCH; c++) begin
        prod4_r[c] <= (2*N)'(layer3_r[c]) * (2*N)'(w3_r);
      end
      pass4_r  <= pass3_r;
      layer4_r <= layer3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: round back to channel scale, or pass the layer through
  // --------------------------------------------------------------------------
  logic [N-1:0] ch5_r [NCH];

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int c = 0; c < NCH; c++) begin
        ch5_r[c] <= pass4_r ? layer4_r[c] : div_round(prod4_r[c]);
      end
    end
  end

  assign out_red   = ch5_r[0];
  assign out_green = ch5_r[1];
  assign out_blue  = ch5_r[2];
  assign out_alpha = ch5_r[3];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TMPM_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, v_r[0])
  `TMPM_ASSERT_NEXT(a_pass_through, ld[5] && v_r[4] && pass4_r,
                    out_red == $past(layer4_r[0]) && out_alpha == $past(layer4_r[3]))
  `TMPM_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                    out_valid && $stable(out_red) && $stable(out_alpha))
  `TMPM_ASSERT_NOW(a_ready_when_free, !v_r[0], in_ready)

endmodule
